### hw/rtl/tdq_pkg.sv
`timescale 1ns / 1ps
package tdq_pkg;
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ID_W = 8;

  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_RESTART = 3'd1;
  localparam logic [2:0] OP_CANCEL  = 3'd2;
  localparam logic [2:0] OP_TICK    = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;

  localparam logic [2:0] ST_EXPIRED  = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_ARMED    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [1:0] SEL_ID   = 2'd0;
  localparam logic [1:0] SEL_PEND = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;

  typedef struct packed {
    logic       load;
    logic       clr_idx;
    logic       inc_idx;
    logic       remove;
    logic       insert;
    logic       capture;
    logic       emit;
    logic [2:0] emit_status;
    logic       emit_last;
    logic [1:0] emit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic       at_end;
    logic       match;
    logic       later;
    logic       full;
    logic       empty;
    logic       front_exp;
    logic       out_free;
    logic [2:0] op;
  } dp_stat_t;
endpackage

### hw/rtl/sorted_deadline_timer_queue.sv
`timescale 1ns / 1ps
// Sorted timer queue of tdq_pkg::DEPTH entries, earliest deadline first; equal deadlines
// keep arrival order. Each input beat with a defined operation gives one or more result
// beats, the final one with last set; other codes give none. Start, restart and cancel
// scan the list one entry a cycle; tick and flush give one result per expired timer or a
// done result. The next input is taken once the last result is in the output register.
module sorted_deadline_timer_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              operation,
  input  logic [tdq_pkg::ID_W-1:0] timer_id,
  input  logic [23:0]             duration,
  input  logic [31:0]             current_time,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              status,
  output logic [tdq_pkg::ID_W-1:0] expired_id,
  output logic                    last
);
  tdq_pkg::dp_cmd_t  cmd;
  tdq_pkg::dp_stat_t stat;

  tdq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .stat(stat), .cmd(cmd)
  );

  tdq_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .operation(operation),
    .timer_id(timer_id), .duration(duration), .current_time(current_time),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .expired_id(expired_id), .last(last)
  );
endmodule

### hw/rtl/tdq_dp.sv
`timescale 1ns / 1ps
module tdq_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  tdq_pkg::dp_cmd_t       cmd,
  output tdq_pkg::dp_stat_t      stat,
  input  logic [2:0]             operation,
  input  logic [tdq_pkg::ID_W-1:0] timer_id,
  input  logic [23:0]            duration,
  input  logic [31:0]            current_time,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             status,
  output logic [tdq_pkg::ID_W-1:0] expired_id,
  output logic                   last
);
  logic [2:0]                    op_reg;
  logic [tdq_pkg::ID_W-1:0]      id_reg;
  logic [23:0]                   dur_reg;
  logic [31:0]                   now_reg;
  logic [tdq_pkg::CNT_W-1:0]     idx;
  logic [tdq_pkg::CNT_W-1:0]     count;
  logic [tdq_pkg::ID_W-1:0]      pend_id;
  logic [tdq_pkg::ID_W-1:0]      slot_id [tdq_pkg::DEPTH];
  logic [31:0]                   slot_start [tdq_pkg::DEPTH];
  logic [23:0]                   slot_duration [tdq_pkg::DEPTH];
  logic [tdq_pkg::IDX_W-1:0]     ix;
  logic [31:0]                   elapsed;
  logic [31:0]                   elapsed0;
  logic [32:0]                   deadline;

  assign ix       = idx[tdq_pkg::IDX_W-1:0];
  assign elapsed  = now_reg - slot_start[ix];
  assign elapsed0 = now_reg - slot_start[0];
  assign deadline = {1'b0, elapsed} + {9'b0, dur_reg};

  always_comb begin
    stat.at_end    = (idx == count);
    stat.match     = (slot_id[ix] == id_reg);
    stat.later     = ({9'b0, slot_duration[ix]} > deadline);
    stat.full      = (count == tdq_pkg::CNT_W'(tdq_pkg::DEPTH));
    stat.empty     = (count == '0);
    stat.front_exp = (elapsed0 >= {8'b0, slot_duration[0]});
    stat.out_free  = !out_valid || out_ready;
    stat.op        = op_reg;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_reg  <= operation;
      id_reg  <= timer_id;
      dur_reg <= duration;
      now_reg <= current_time;
    end
    if (cmd.capture) pend_id <= slot_id[0];
    if (cmd.remove) begin
      for (int i = 0; i < tdq_pkg::DEPTH - 1; i++) begin
        if (tdq_pkg::IDX_W'(i) >= ix) begin
          slot_id[i]       <= slot_id[i+1];
          slot_start[i]    <= slot_start[i+1];
          slot_duration[i] <= slot_duration[i+1];
        end
      end
    end else if (cmd.insert) begin
      for (int i = 1; i < tdq_pkg::DEPTH; i++) begin
        if (tdq_pkg::IDX_W'(i) > ix) begin
          slot_id[i]       <= slot_id[i-1];
          slot_start[i]    <= slot_start[i-1];
          slot_duration[i] <= slot_duration[i-1];
        end
      end
      slot_id[ix]       <= id_reg;
      slot_start[ix]    <= now_reg;
      slot_duration[ix] <= dur_reg;
    end
    if (cmd.emit) begin
      status <= cmd.emit_status;
      last   <= cmd.emit_last;
      unique case (cmd.emit_sel)
        tdq_pkg::SEL_ID:   expired_id <= id_reg;
        tdq_pkg::SEL_PEND: expired_id <= pend_id;
        default:           expired_id <= '0;
      endcase
    end
    if (rst) begin
      idx       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_idx)      idx <= '0;
      else if (cmd.inc_idx) idx <= idx + tdq_pkg::CNT_W'(1);
      if (cmd.remove)       count <= count - tdq_pkg::CNT_W'(1);
      else if (cmd.insert)  count <= count + tdq_pkg::CNT_W'(1);
      if (cmd.emit)         out_valid <= 1'b1;
      else if (out_ready)   out_valid <= 1'b0;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= tdq_pkg::CNT_W'(tdq_pkg::DEPTH))
    else $error("count beyond depth");
  a_no_ins_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !stat.full)
    else $error("insert into full queue");
  a_no_rm_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |-> !stat.empty && idx < count)
    else $error("remove outside queue");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result overwritten");
endmodule

### hw/rtl/tdq_ctrl.sv
`timescale 1ns / 1ps
module tdq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        operation,
  input  tdq_pkg::dp_stat_t stat,
  output tdq_pkg::dp_cmd_t  cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_INS  = 2'd2;
  localparam logic [1:0] S_TICK = 2'd3;

  logic [1:0] state, state_next;
  logic       pend, pend_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    pend_next  = pend;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.clr_idx = 1'b1;
          pend_next   = 1'b0;
          if (operation == tdq_pkg::OP_TICK || operation == tdq_pkg::OP_FLUSH)
            state_next = S_TICK;
          else if (operation == tdq_pkg::OP_START || operation == tdq_pkg::OP_RESTART ||
                   operation == tdq_pkg::OP_CANCEL)
            state_next = S_FIND;
        end
      end
      S_FIND: begin
        cmd.emit_sel  = tdq_pkg::SEL_ID;
        cmd.emit_last = 1'b1;
        if (stat.at_end) begin
          if (stat.op == tdq_pkg::OP_CANCEL) begin
            cmd.emit_status = tdq_pkg::ST_NOTFOUND;
            cmd.emit        = stat.out_free;
            if (stat.out_free) state_next = S_IDLE;
          end else if (stat.full) begin
            cmd.emit_status = tdq_pkg::ST_FULL;
            cmd.emit        = stat.out_free;
            if (stat.out_free) state_next = S_IDLE;
          end else begin
            cmd.clr_idx = 1'b1;
            state_next  = S_INS;
          end
        end else if (stat.match) begin
          if (stat.op == tdq_pkg::OP_START) begin
            cmd.emit_status = tdq_pkg::ST_ARMED;
            cmd.emit        = stat.out_free;
            if (stat.out_free) state_next = S_IDLE;
          end else if (stat.op == tdq_pkg::OP_RESTART) begin
            cmd.remove  = 1'b1;
            cmd.clr_idx = 1'b1;
            state_next  = S_INS;
          end else begin
            cmd.emit_status = tdq_pkg::ST_DONE;
            cmd.emit        = stat.out_free;
            cmd.remove      = stat.out_free;
            if (stat.out_free) state_next = S_IDLE;
          end
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      S_INS: begin
        cmd.emit_sel    = tdq_pkg::SEL_ID;
        cmd.emit_last   = 1'b1;
        cmd.emit_status = tdq_pkg::ST_DONE;
        if (stat.at_end || stat.later) begin
          cmd.emit   = stat.out_free;
          cmd.insert = stat.out_free;
          if (stat.out_free) state_next = S_IDLE;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      default: begin
        cmd.emit_status = pend ? tdq_pkg::ST_EXPIRED : tdq_pkg::ST_DONE;
        cmd.emit_sel    = pend ? tdq_pkg::SEL_PEND : tdq_pkg::SEL_ZERO;
        if (!stat.empty && (stat.op == tdq_pkg::OP_FLUSH || stat.front_exp)) begin
          if (!pend || stat.out_free) begin
            cmd.emit    = pend;
            cmd.capture = 1'b1;
            cmd.remove  = 1'b1;
            pend_next   = 1'b1;
          end
        end else begin
          cmd.emit_last = 1'b1;
          cmd.emit      = stat.out_free;
          if (stat.out_free) state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE)
    else $error("load outside idle");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.emit_last |=> state == S_IDLE)
    else $error("final result not ending item");
  a_pend_tick: assert property (@(posedge clk) disable iff (rst)
    pend && state != S_IDLE |-> state == S_TICK)
    else $error("pending expiry outside tick");
endmodule

### test/sorted_deadline_timer_queue_checker.sv
`timescale 1ns / 1ps
module sorted_deadline_timer_queue_checker
  import tdq_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [2:0]      operation,
  input  logic [ID_W-1:0] timer_id,
  input  logic [23:0]     duration,
  input  logic [31:0]     current_time,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic [2:0]      status,
  input  logic [ID_W-1:0] expired_id,
  input  logic            last,
  output int              errors,
  output int              pending,
  output int              results_seen,
  output int              expiries_seen
);
  typedef struct packed {
    logic [2:0]      status;
    logic [ID_W-1:0] id;
    logic            last;
  } result_t;

  logic [ID_W-1:0] q_id [DEPTH];
  logic [31:0]     q_start [DEPTH];
  logic [23:0]     q_dur [DEPTH];
  int              armed;
  result_t         expected_results[$];

  assign pending = expected_results.size();

  function automatic int find_timer(logic [ID_W-1:0] id);
    for (int i = 0; i < armed; i++)
      if (q_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_timer(int pos);
    for (int i = pos; i + 1 < armed; i++) begin
      q_id[i] = q_id[i+1];
      q_start[i] = q_start[i+1];
      q_dur[i] = q_dur[i+1];
    end
    armed--;
  endfunction

  function automatic void arm_timer(logic [ID_W-1:0] id, logic [23:0] dur, logic [31:0] now);
    int pos;
    logic [31:0] el;
    longint rem;
    pos = armed;
    for (int i = 0; i < armed; i++) begin
      el = now - q_start[i];
      rem = longint'(q_dur[i]) - longint'(el);
      if (rem > longint'(dur)) begin
        pos = i;
        break;
      end
    end
    for (int i = armed; i > pos; i--) begin
      q_id[i] = q_id[i-1];
      q_start[i] = q_start[i-1];
      q_dur[i] = q_dur[i-1];
    end
    q_id[pos] = id;
    q_start[pos] = now;
    q_dur[pos] = dur;
    armed++;
  endfunction

  function automatic void push_result(logic [2:0] st, logic [ID_W-1:0] id, logic lst);
    result_t r;
    r.status = st;
    r.id = id;
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void predict(logic [2:0] op, logic [ID_W-1:0] id, logic [23:0] dur,
                                  logic [31:0] now);
    int pos;
    int n;
    case (op)
      OP_START: begin
        if (find_timer(id) >= 0) push_result(ST_ARMED, id, 1'b1);
        else if (armed >= DEPTH) push_result(ST_FULL, id, 1'b1);
        else begin
          arm_timer(id, dur, now);
          push_result(ST_DONE, id, 1'b1);
        end
      end
      OP_RESTART: begin
        pos = find_timer(id);
        if (pos < 0 && armed >= DEPTH) push_result(ST_FULL, id, 1'b1);
        else begin
          if (pos >= 0) drop_timer(pos);
          arm_timer(id, dur, now);
          push_result(ST_DONE, id, 1'b1);
        end
      end
      OP_CANCEL: begin
        pos = find_timer(id);
        if (pos < 0) push_result(ST_NOTFOUND, id, 1'b1);
        else begin
          drop_timer(pos);
          push_result(ST_DONE, id, 1'b1);
        end
      end
      OP_TICK, OP_FLUSH: begin
        n = 0;
        while (armed > 0) begin
          if (op == OP_TICK && (now - q_start[0]) < {8'd0, q_dur[0]}) break;
          push_result(ST_EXPIRED, q_id[0], 1'b0);
          drop_timer(0);
          n++;
        end
        if (n == 0) push_result(ST_DONE, '0, 1'b1);
        else expected_results[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      armed = 0;
      expected_results.delete();
      errors = 0;
      results_seen = 0;
      expiries_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (status == ST_EXPIRED) expiries_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat: status %0d id %0d last %0b",
                     status, expired_id, last);
        end else begin
          e = expected_results.pop_front();
          if (e.status !== status || e.id !== expired_id || e.last !== last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected status %0d id %0d last %0b, got %0d %0d %0b",
                       e.status, e.id, e.last, status, expired_id, last);
          end
        end
      end
      if (in_valid && in_ready) predict(operation, timer_id, duration, current_time);
    end
  end
endmodule

### test/sorted_deadline_timer_queue_test.sv
`timescale 1ns / 1ps
module sorted_deadline_timer_queue_test;
  import tdq_pkg::*;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [2:0]      operation = OP_TICK;
  logic [ID_W-1:0] timer_id = '0;
  logic [23:0]     duration = '0;
  logic [31:0]     current_time = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [2:0]      status;
  logic [ID_W-1:0] expired_id;
  logic            last;
  int              errors, pending, results_seen, expiries_seen;
  int              items_sent = 0;
  int              idle_cycles = 0;
  bit              hold_off = 1'b0;
  logic [31:0]     now_s = 32'd1000;
  logic [ID_W-1:0] id_pool [8];

  localparam int WATCHDOG = 20000;

  always #5 clk = ~clk;

  sorted_deadline_timer_queue DUT (.*);

  sorted_deadline_timer_queue_checker chk (.*);

  task automatic send(input logic [2:0] op, input logic [ID_W-1:0] id,
                      input logic [23:0] dur, input logic [31:0] now);
    operation <= op;
    timer_id <= id;
    duration <= dur;
    current_time <= now;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_item(input bit noise);
    int k;
    logic [2:0] op;
    logic [ID_W-1:0] id;
    logic [23:0] dur;
    k = $urandom_range(0, 99);
    id = noise ? ID_W'($urandom) : id_pool[$urandom_range(0, 7)];
    case ($urandom_range(0, 3))
      0: dur = 24'($urandom);
      1: dur = 24'hFFFFFF;
      default: dur = 24'($urandom_range(0, 40));
    endcase
    if (k < 35) op = OP_START;
    else if (k < 50) op = OP_RESTART;
    else if (k < 63) op = OP_CANCEL;
    else if (k < 92) op = OP_TICK;
    else if (k < 96) op = OP_FLUSH;
    else op = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 30) == 0) now_s = $urandom;
    else now_s = now_s + $urandom_range(0, 12);
    send(op, id, dur, now_s);
  endtask

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0) || items_sent < 20;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG && !hold_off) begin
      $display("watchdog timeout");
      $display("FAIL sorted_deadline_timer_queue");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) id_pool[i] = ID_W'($urandom);
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send(OP_TICK, 8'd5, 24'd0, 32'd0);
    send(OP_FLUSH, 8'd5, 24'd0, 32'd0);
    send(OP_CANCEL, 8'd7, 24'd0, 32'd0);
    send(OP_START, 8'd0, 24'd0, 32'hFFFF_FFF0);
    send(OP_START, 8'd255, 24'hFFFFFF, 32'hFFFF_FFF0);
    send(OP_START, 8'd255, 24'd3, 32'hFFFF_FFF0);
    send(OP_START, 8'd10, 24'd20, 32'hFFFF_FFF0);
    send(OP_START, 8'd11, 24'd20, 32'hFFFF_FFF0);
    send(OP_RESTART, 8'd10, 24'd20, 32'hFFFF_FFF0);
    send(OP_RESTART, 8'd12, 24'd5, 32'hFFFF_FFF5);
    send(3'd6, 8'd12, 24'd5, 32'd0);
    send(OP_TICK, 8'd0, 24'd0, 32'h0000_0004);
    send(OP_CANCEL, 8'd11, 24'd0, 32'd5);
    send(OP_CANCEL, 8'd11, 24'd0, 32'd5);
    send(OP_FLUSH, 8'd0, 24'd0, 32'd6);
    for (int i = 0; i < DEPTH; i++) send(OP_START, ID_W'(i + 100), 24'(i % 3), 32'd50);
    send(OP_START, 8'd1, 24'd1, 32'd50);
    send(OP_RESTART, 8'd2, 24'd1, 32'd50);
    send(OP_RESTART, 8'd100, 24'hFFFFFF, 32'd50);
    send(OP_TICK, 8'd0, 24'd0, 32'hAAAA_AAAA);
    send(OP_FLUSH, 8'd0, 24'd0, 32'h5555_5555);

    // long receiver hold-off while sender keeps offering
    hold_off = 1'b1;
    fork
      repeat (300) @(posedge clk);
      for (int i = 0; i < 30; i++) random_item(1'b0);
    join_any
    hold_off = 1'b0;
    wait fork;

    // sender waits for all results
    drain();

    while (items_sent < 400) begin
      for (int b = $urandom_range(1, 20); b > 0; b--) random_item($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 15));
      if ($urandom_range(0, 10) == 0) drain();
    end
    drain();
    repeat (20) @(posedge clk);

    $display("%0d input beats, %0d result beats, %0d timer expiries checked",
             items_sent, results_seen, expiries_seen);
    if (errors == 0 && pending == 0) $display("PASS sorted_deadline_timer_queue");
    else $display("FAIL sorted_deadline_timer_queue");
    $finish;
  end
endmodule
